[rtl/tlcc_pkg.sv]
package tlcc_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_FETCH = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] POL_LRU  = 2'd0;
  localparam logic [1:0] POL_LFU  = 2'd1;
  localparam logic [1:0] POL_FIFO = 2'd2;
  localparam logic [1:0] POL_RSVD = 2'd3;

  localparam logic [2:0] REG_REPL  = 3'd0;
  localparam logic [2:0] REG_WRITE = 3'd1;
  localparam logic [2:0] REG_IBB   = 3'd2;
  localparam logic [2:0] REG_DBB   = 3'd3;
  localparam logic [2:0] REG_L2BB  = 3'd4;

  localparam int FILL_W = 4;
  localparam int FPTR_W = 3;
  localparam int SST_W  = FILL_W + FPTR_W;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 32;

endpackage

[rtl/two_level_cache_controller_top.sv]
// Tag controller for split L1 instruction and data caches backed by a unified L2.
// One access is in flight at a time; in_ready is high only when the block is idle.
// Each cache level visited costs one pass through its set (address, set read,
// scan of its n ways, decide), where n is that cache's associativity; all passes
// use the single shared way-scan unit, fed one way per cycle from the tag memory.
// Acceptance and the result hand-off are separate steps around the passes. An L1
// miss adds an L2 pass, except a store miss with the write policy bit set, and a
// dirty data cache victim written into L2 adds one more L2 pass.
// A result beat that has not been taken holds the block in its last step.
// After reset, the per-set fill and FIFO state is cleared before the first
// access is taken.
module two_level_cache_controller_top #(
  parameter int INST_INDEX_BITS = 6,
  parameter int DATA_INDEX_BITS = 6,
  parameter int L2_SET_BITS     = 8,
  parameter int L1_WAY_BITS     = 2,
  parameter int L2_WAY_BITS     = 3,
  parameter int ADDRESS_BITS    = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ADDRESS_BITS-1:0] in_address,
  input  logic [1:0]              in_opcode,
  input  logic [31:0]             in_access_time,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_l1_hit,
  output logic                    out_l2_accessed,
  output logic                    out_l2_hit,
  output logic                    out_l1_evicted,
  output logic [1:0]              out_l2_evictions,
  output logic [1:0]              out_l2_writebacks,
  output logic [1:0]              out_memory_block_transfers,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [3:0]              cfg_data
);

  localparam int AW      = ADDRESS_BITS;
  localparam int TW      = tlcc_pkg::TIME_W;
  localparam int CW      = tlcc_pkg::CNT_W;
  localparam int FW      = tlcc_pkg::FILL_W;
  localparam int PW      = tlcc_pkg::FPTR_W;
  localparam int SW      = tlcc_pkg::SST_W;
  localparam int EW      = 2*AW + TW + CW + 1;
  localparam int DIRTY_B = CW + TW;
  localparam int TAG_LO  = DIRTY_B + 1;
  localparam int LINE_LO = TAG_LO + AW;
  localparam int L1N     = 1 << L1_WAY_BITS;
  localparam int L2N     = 1 << L2_WAY_BITS;
  localparam int MAXWB   = (L1_WAY_BITS > L2_WAY_BITS) ? L1_WAY_BITS : L2_WAY_BITS;
  localparam int WIW     = (MAXWB > 0) ? MAXWB : 1;
  localparam int KW      = MAXWB + 1;
  localparam int MAXID1  = (INST_INDEX_BITS > DATA_INDEX_BITS) ? INST_INDEX_BITS
                                                                : DATA_INDEX_BITS;
  localparam int MAXIDX  = (MAXID1 > L2_SET_BITS) ? MAXID1 : L2_SET_BITS;
  localparam int SETW    = (MAXIDX > 0) ? MAXIDX : 1;
  localparam int I_SW    = (INST_INDEX_BITS > 0) ? INST_INDEX_BITS : 1;
  localparam int D_SW    = (DATA_INDEX_BITS > 0) ? DATA_INDEX_BITS : 1;
  localparam int U_SW    = (L2_SET_BITS > 0) ? L2_SET_BITS : 1;
  localparam int I_EA    = (INST_INDEX_BITS + L1_WAY_BITS > 0) ?
                           INST_INDEX_BITS + L1_WAY_BITS : 1;
  localparam int D_EA    = (DATA_INDEX_BITS + L1_WAY_BITS > 0) ?
                           DATA_INDEX_BITS + L1_WAY_BITS : 1;
  localparam int U_EA    = (L2_SET_BITS + L2_WAY_BITS > 0) ?
                           L2_SET_BITS + L2_WAY_BITS : 1;
  localparam logic [SETW-1:0] I_MASK  = SETW'((1 << INST_INDEX_BITS) - 1);
  localparam logic [SETW-1:0] D_MASK  = SETW'((1 << DATA_INDEX_BITS) - 1);
  localparam logic [SETW-1:0] U_MASK  = SETW'((1 << L2_SET_BITS) - 1);
  localparam logic [SETW-1:0] CLR_END = SETW'((1 << MAXIDX) - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ADDR, ST_SETRD, ST_SCAN, ST_DECIDE, ST_DONE
  } state_t;

  typedef enum logic [1:0] { PH_L1, PH_L2, PH_WB } phase_t;

  state_t  st_r;
  phase_t  phase_r;
  logic [SETW-1:0] clr_r;
  logic [KW-1:0]   k_r;

  logic [1:0] repl_r;
  logic       wpol_r;
  logic [3:0] ibb_r, dbb_r, ubb_r;

  logic [AW-1:0]   addr_r;
  logic [1:0]      op_r;
  logic [TW-1:0]   t_r;
  logic [SETW-1:0] set_r;
  logic [AW-1:0]   tag_r;
  logic            wb_pend_r;
  logic [AW-1:0]   wb_line_r;
  logic [TW-1:0]   wb_time_r;

  logic       res_l1hit_r, res_l2acc_r, res_l2hit_r, res_l1ev_r;
  logic [1:0] res_l2ev_r, res_l2wb_r, res_mem_r;

  logic       out_valid_r;
  logic       o_l1hit_r, o_l2acc_r, o_l2hit_r, o_l1ev_r;
  logic [1:0] o_l2ev_r, o_l2wb_r, o_mem_r;

  logic use_l2, use_i, use_d, is_store;
  logic [KW-1:0]  cur_n;
  logic [WIW-1:0] way_mask;
  logic [SW-1:0]  sst_q, i_sst_q, d_sst_q, u_sst_q;
  logic [FW-1:0]  fill;
  logic [PW-1:0]  fptr;
  logic [WIW-1:0] fifo_way;
  logic [EW-1:0]  ent_q, i_ent_q, d_ent_q, u_ent_q;
  logic           full;

  logic [AW-1:0]   src;
  logic [3:0]      bb;
  logic [4:0]      idx_bits;
  logic [SETW-1:0] idx_mask;
  logic [AW-1:0]   shifted;
  logic [SETW-1:0] set_nxt;
  logic [AW-1:0]   tag_nxt;

  logic           sc_hit;
  logic [WIW-1:0] sc_hit_way, sc_vic_way;
  logic [EW-1:0]  sc_hit_ent, sc_vic_ent;
  logic           sc_en, sc_clr;
  logic [WIW-1:0] sc_way;

  logic           deciding, do_touch, do_place, ent_we;
  logic [WIW-1:0] place_way, wr_way;
  logic [SW-1:0]  sst_new, sst_wdata;
  logic [EW-1:0]  touch_ent, place_ent, ent_wdata;
  logic [CW-1:0]  hit_cnt;
  logic           vic_dirty, new_dirty, place_dirty;
  logic [TW-1:0]  place_time;
  logic           clearing, sst_re, ent_re;
  logic [SETW-1:0] sst_addr;

  assign use_l2   = (phase_r != PH_L1);
  assign use_i    = !use_l2 && (op_r == tlcc_pkg::OP_FETCH);
  assign use_d    = !use_l2 && !use_i;
  assign is_store = (op_r == tlcc_pkg::OP_STORE);
  assign cur_n    = use_l2 ? KW'(L2N) : KW'(L1N);
  assign way_mask = use_l2 ? WIW'(L2N - 1) : WIW'(L1N - 1);
  assign sst_q    = use_l2 ? u_sst_q : (use_i ? i_sst_q : d_sst_q);
  assign fill     = sst_q[FW-1:0];
  assign fptr     = sst_q[SW-1:FW];
  assign fifo_way = WIW'(fptr) & way_mask;
  assign ent_q    = use_l2 ? u_ent_q : (use_i ? i_ent_q : d_ent_q);
  assign full     = (fill == FW'(cur_n));

  // Set index and tag of the address the current pass works on.
  always_comb begin
    src      = (phase_r == PH_WB) ? wb_line_r : addr_r;
    bb       = use_l2 ? ubb_r : (use_i ? ibb_r : dbb_r);
    idx_bits = use_l2 ? 5'(L2_SET_BITS) :
               (use_i ? 5'(INST_INDEX_BITS) : 5'(DATA_INDEX_BITS));
    idx_mask = use_l2 ? U_MASK : (use_i ? I_MASK : D_MASK);
    shifted  = src >> bb;
    set_nxt  = SETW'(shifted) & idx_mask;
    tag_nxt  = src >> (6'(bb) + 6'(idx_bits));
  end

  assign sc_clr = (st_r == ST_SETRD);
  assign sc_en  = (st_r == ST_SCAN) && (k_r != '0);
  assign sc_way = WIW'(k_r - KW'(1));

  tlcc_scan #(.AW(AW), .WIW(WIW)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (sc_clr),
    .en       (sc_en),
    .way      (sc_way),
    .ent      (ent_q),
    .tag      (tag_r),
    .fill     (fill),
    .fifo_way (fifo_way),
    .policy   (repl_r),
    .hit      (sc_hit),
    .hit_way  (sc_hit_way),
    .hit_ent  (sc_hit_ent),
    .vic_way  (sc_vic_way),
    .vic_ent  (sc_vic_ent)
  );

  always_comb begin
    deciding = (st_r == ST_DECIDE);
    do_touch = deciding && (phase_r != PH_WB) && sc_hit;
    do_place = deciding && !do_touch &&
               !((phase_r == PH_L1) && is_store && wpol_r);
    ent_we   = do_touch || do_place;

    place_way = full ? sc_vic_way : WIW'(fill);
    sst_new[FW-1:0] = full ? fill : fill + FW'(1);
    if (full && (repl_r == tlcc_pkg::POL_FIFO)) begin
      sst_new[SW-1:FW] = PW'((sc_vic_way + WIW'(1)) & way_mask);
    end else begin
      sst_new[SW-1:FW] = fptr;
    end
    vic_dirty = sc_vic_ent[DIRTY_B];

    hit_cnt = sc_hit_ent[CW-1:0];
    if (phase_r == PH_L1) begin
      new_dirty = sc_hit_ent[DIRTY_B] || is_store;
    end else begin
      // An L2 store hit leaves the line clean.
      new_dirty = is_store ? 1'b0 : sc_hit_ent[DIRTY_B];
    end
    touch_ent = sc_hit_ent;
    touch_ent[DIRTY_B] = new_dirty;
    touch_ent[CW +: TW] = t_r;
    touch_ent[CW-1:0] = (hit_cnt == '1) ? hit_cnt : hit_cnt + CW'(1);

    place_dirty = (phase_r == PH_WB) || ((phase_r == PH_L1) && is_store);
    place_time  = (phase_r == PH_WB) ? wb_time_r : t_r;
    place_ent   = {src, tag_r, place_dirty, place_time, CW'(1)};

    wr_way    = do_touch ? sc_hit_way : place_way;
    ent_wdata = do_touch ? touch_ent : place_ent;
  end

  assign clearing  = (st_r == ST_CLEAR);
  assign sst_re    = (st_r == ST_SETRD);
  assign ent_re    = (st_r == ST_SCAN) && (k_r < cur_n);
  assign sst_addr  = clearing ? clr_r : set_r;
  assign sst_wdata = clearing ? '0 : sst_new;

  tlcc_ram #(.WIDTH(SW), .DEPTH(1 << INST_INDEX_BITS)) u_i_sst (
    .clk (clk), .we (clearing || (do_place && use_i)), .waddr (I_SW'(sst_addr)),
    .wdata (sst_wdata), .re (sst_re && use_i), .raddr (I_SW'(set_r)), .rdata (i_sst_q)
  );
  tlcc_ram #(.WIDTH(SW), .DEPTH(1 << DATA_INDEX_BITS)) u_d_sst (
    .clk (clk), .we (clearing || (do_place && use_d)), .waddr (D_SW'(sst_addr)),
    .wdata (sst_wdata), .re (sst_re && use_d), .raddr (D_SW'(set_r)), .rdata (d_sst_q)
  );
  tlcc_ram #(.WIDTH(SW), .DEPTH(1 << L2_SET_BITS)) u_u_sst (
    .clk (clk), .we (clearing || (do_place && use_l2)), .waddr (U_SW'(sst_addr)),
    .wdata (sst_wdata), .re (sst_re && use_l2), .raddr (U_SW'(set_r)), .rdata (u_sst_q)
  );

  tlcc_ram #(.WIDTH(EW), .DEPTH(1 << (INST_INDEX_BITS + L1_WAY_BITS))) u_i_ent (
    .clk   (clk),
    .we    (ent_we && use_i),
    .waddr (I_EA'((I_EA'(set_r) << L1_WAY_BITS) + I_EA'(wr_way))),
    .wdata (ent_wdata),
    .re    (ent_re && use_i),
    .raddr (I_EA'((I_EA'(set_r) << L1_WAY_BITS) + I_EA'(k_r))),
    .rdata (i_ent_q)
  );
  tlcc_ram #(.WIDTH(EW), .DEPTH(1 << (DATA_INDEX_BITS + L1_WAY_BITS))) u_d_ent (
    .clk   (clk),
    .we    (ent_we && use_d),
    .waddr (D_EA'((D_EA'(set_r) << L1_WAY_BITS) + D_EA'(wr_way))),
    .wdata (ent_wdata),
    .re    (ent_re && use_d),
    .raddr (D_EA'((D_EA'(set_r) << L1_WAY_BITS) + D_EA'(k_r))),
    .rdata (d_ent_q)
  );
  tlcc_ram #(.WIDTH(EW), .DEPTH(1 << (L2_SET_BITS + L2_WAY_BITS))) u_u_ent (
    .clk   (clk),
    .we    (ent_we && use_l2),
    .waddr (U_EA'((U_EA'(set_r) << L2_WAY_BITS) + U_EA'(wr_way))),
    .wdata (ent_wdata),
    .re    (ent_re && use_l2),
    .raddr (U_EA'((U_EA'(set_r) << L2_WAY_BITS) + U_EA'(k_r))),
    .rdata (u_ent_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      phase_r     <= PH_L1;
      clr_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      wb_pend_r   <= 1'b0;
      repl_r      <= tlcc_pkg::POL_LRU;
      wpol_r      <= 1'b0;
      ibb_r       <= 4'd6;
      dbb_r       <= 4'd6;
      ubb_r       <= 4'd6;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tlcc_pkg::REG_REPL:  repl_r <= cfg_data[1:0];
          tlcc_pkg::REG_WRITE: wpol_r <= cfg_data[0];
          tlcc_pkg::REG_IBB:   ibb_r  <= cfg_data;
          tlcc_pkg::REG_DBB:   dbb_r  <= cfg_data;
          tlcc_pkg::REG_L2BB:  ubb_r  <= cfg_data;
          default: ;
        endcase
      end
      // In ST_DONE the output register is reloaded below instead.
      if (out_valid_r && out_ready && (st_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (st_r)
        ST_CLEAR: begin
          clr_r <= clr_r + SETW'(1);
          if (clr_r == CLR_END) begin
            st_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            addr_r      <= in_address;
            op_r        <= in_opcode;
            t_r         <= in_access_time;
            phase_r     <= PH_L1;
            wb_pend_r   <= 1'b0;
            res_l1hit_r <= 1'b0;
            res_l2acc_r <= 1'b0;
            res_l2hit_r <= 1'b0;
            res_l1ev_r  <= 1'b0;
            res_l2ev_r  <= '0;
            res_l2wb_r  <= '0;
            res_mem_r   <= '0;
            st_r <= (in_opcode == tlcc_pkg::OP_NONE) ? ST_DONE : ST_ADDR;
          end
        end
        ST_ADDR: begin
          set_r <= set_nxt;
          tag_r <= tag_nxt;
          st_r  <= ST_SETRD;
        end
        ST_SETRD: begin
          k_r  <= '0;
          st_r <= ST_SCAN;
        end
        ST_SCAN: begin
          // Way k is read while the scan unit judges way k-1.
          if (k_r == cur_n) begin
            st_r <= ST_DECIDE;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        ST_DECIDE: begin
          case (phase_r)
            PH_L1: begin
              if (sc_hit) begin
                res_l1hit_r <= 1'b1;
                res_mem_r   <= 2'(is_store && wpol_r);
                st_r        <= ST_DONE;
              end else if (is_store && wpol_r) begin
                res_l2acc_r <= 1'b1;
                res_mem_r   <= 2'd1;
                st_r        <= ST_DONE;
              end else begin
                res_l1ev_r <= full;
                wb_pend_r  <= use_d && !wpol_r && full && vic_dirty;
                wb_line_r  <= sc_vic_ent[LINE_LO +: AW];
                wb_time_r  <= sc_vic_ent[CW +: TW];
                phase_r    <= PH_L2;
                st_r       <= ST_ADDR;
              end
            end
            PH_L2: begin
              res_l2acc_r <= 1'b1;
              if (sc_hit) begin
                res_l2hit_r <= 1'b1;
              end else begin
                res_l2ev_r <= res_l2ev_r + 2'(full);
                res_l2wb_r <= res_l2wb_r + 2'(full && !wpol_r && vic_dirty);
                res_mem_r  <= res_mem_r + 2'd1 + 2'(full && !wpol_r && vic_dirty);
              end
              if (wb_pend_r) begin
                phase_r <= PH_WB;
                st_r    <= ST_ADDR;
              end else begin
                st_r <= ST_DONE;
              end
            end
            default: begin
              res_l2ev_r <= res_l2ev_r + 2'(full);
              res_l2wb_r <= res_l2wb_r + 2'(full && !wpol_r && vic_dirty);
              res_mem_r  <= res_mem_r + 2'(full && !wpol_r && vic_dirty);
              st_r       <= ST_DONE;
            end
          endcase
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            o_l1hit_r   <= res_l1hit_r;
            o_l2acc_r   <= res_l2acc_r;
            o_l2hit_r   <= res_l2hit_r;
            o_l1ev_r    <= res_l1ev_r;
            o_l2ev_r    <= res_l2ev_r;
            o_l2wb_r    <= res_l2wb_r;
            o_mem_r     <= res_mem_r;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready                   = (st_r == ST_IDLE);
  assign cfg_ready                  = 1'b1;
  assign out_valid                  = out_valid_r;
  assign out_l1_hit                 = o_l1hit_r;
  assign out_l2_accessed            = o_l2acc_r;
  assign out_l2_hit                 = o_l2hit_r;
  assign out_l1_evicted             = o_l1ev_r;
  assign out_l2_evictions           = o_l2ev_r;
  assign out_l2_writebacks          = o_l2wb_r;
  assign out_memory_block_transfers = o_mem_r;

endmodule

[rtl/tlcc_ram.sv]
module tlcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/tlcc_scan.sv]
module tlcc_scan #(
  parameter int AW  = 48,
  parameter int WIW = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clr,
  input  logic                   en,
  input  logic [WIW-1:0]         way,
  input  logic [2*AW+tlcc_pkg::TIME_W+tlcc_pkg::CNT_W:0] ent,
  input  logic [AW-1:0]          tag,
  input  logic [tlcc_pkg::FILL_W-1:0] fill,
  input  logic [WIW-1:0]         fifo_way,
  input  logic [1:0]             policy,
  output logic                   hit,
  output logic [WIW-1:0]         hit_way,
  output logic [2*AW+tlcc_pkg::TIME_W+tlcc_pkg::CNT_W:0] hit_ent,
  output logic [WIW-1:0]         vic_way,
  output logic [2*AW+tlcc_pkg::TIME_W+tlcc_pkg::CNT_W:0] vic_ent
);

  localparam int EW       = 2*AW + tlcc_pkg::TIME_W + tlcc_pkg::CNT_W + 1;
  localparam int TIME_LO  = tlcc_pkg::CNT_W;
  localparam int TAG_LO   = tlcc_pkg::CNT_W + tlcc_pkg::TIME_W + 1;

  logic           hit_r;
  logic [WIW-1:0] hit_way_r;
  logic [EW-1:0]  hit_ent_r;
  logic [WIW-1:0] vic_way_r;
  logic [EW-1:0]  vic_ent_r;
  logic           match;
  logic           take;
  logic [tlcc_pkg::CNT_W-1:0]  e_cnt, v_cnt;
  logic [tlcc_pkg::TIME_W-1:0] e_time, v_time;
  logic [AW-1:0]  e_tag, v_tag;

  always_comb begin
    e_cnt  = ent[tlcc_pkg::CNT_W-1:0];
    v_cnt  = vic_ent_r[tlcc_pkg::CNT_W-1:0];
    e_time = ent[TIME_LO +: tlcc_pkg::TIME_W];
    v_time = vic_ent_r[TIME_LO +: tlcc_pkg::TIME_W];
    e_tag  = ent[TAG_LO +: AW];
    v_tag  = vic_ent_r[TAG_LO +: AW];
    match  = !hit_r && (tlcc_pkg::FILL_W'(way) < fill) && (e_tag == tag);
    if (policy == tlcc_pkg::POL_FIFO) begin
      take = (way == fifo_way);
    end else if (way == '0) begin
      take = 1'b1;
    end else if (policy == tlcc_pkg::POL_LFU) begin
      take = (e_cnt < v_cnt) || ((e_cnt == v_cnt) && (e_tag < v_tag));
    end else begin
      take = (e_time < v_time);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      hit_r <= 1'b0;
    end else if (en && match) begin
      hit_r <= 1'b1;
    end
    if (en && match) begin
      hit_way_r <= way;
      hit_ent_r <= ent;
    end
    if (en && take) begin
      vic_way_r <= way;
      vic_ent_r <= ent;
    end
  end

  assign hit     = hit_r;
  assign hit_way = hit_way_r;
  assign hit_ent = hit_ent_r;
  assign vic_way = vic_way_r;
  assign vic_ent = vic_ent_r;

endmodule

[dv/tlcc_access_checker.sv]
`timescale 1ns / 1ps

module tlcc_access_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [47:0] in_address,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_access_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_l1_hit,
  input  logic        out_l2_accessed,
  input  logic        out_l2_hit,
  input  logic        out_l1_evicted,
  input  logic [1:0]  out_l2_evictions,
  input  logic [1:0]  out_l2_writebacks,
  input  logic [1:0]  out_memory_block_transfers,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output int          pending,
  output int          mismatches
);

  localparam int ICACHE = 0;
  localparam int DCACHE = 1;
  localparam int UCACHE = 2;

  typedef struct packed {
    logic       l1_hit;
    logic       l2_accessed;
    logic       l2_hit;
    logic       l1_evicted;
    logic [1:0] l2_evictions;
    logic [1:0] l2_writebacks;
    logic [1:0] transfers;
  } access_outcome_t;

  access_outcome_t outcome_q[$];

  logic [1:0] repl;
  logic       wpol;
  logic [3:0] ibb, dbb, l2bb;

  logic [47:0] tag_mem [3][2048];
  bit          vld [3][2048];
  bit          drt [3][2048];
  logic [31:0] stamp [3][2048];
  logic [31:0] uses [3][2048];
  logic [47:0] line_mem [2048];
  int          fill_lvl [3][256];
  int          fifo_ptr [3][256];

  // Running tallies of the access being predicted.
  bit r_l1hit, r_l2acc, r_l2hit, r_l1ev;
  int r_l2ev, r_wb, r_xfer;

  function automatic int way_bits(int c);
    return (c == UCACHE) ? 3 : 2;
  endfunction

  function automatic int set_of(int c, logic [47:0] a, logic [3:0] bb);
    int ib;
    ib = (c == UCACHE) ? 8 : 6;
    return int'((a >> bb) & ((48'd1 << ib) - 48'd1));
  endfunction

  function automatic logic [47:0] tag_of(int c, logic [47:0] a, logic [3:0] bb);
    int ib;
    ib = (c == UCACHE) ? 8 : 6;
    return a >> (bb + ib);
  endfunction

  function automatic int find_way(int c, int s, logic [47:0] tg);
    int n;
    int base;
    n = 1 << way_bits(c);
    base = s << way_bits(c);
    for (int i = 0; i < n; i++)
      if (vld[c][base+i] && tag_mem[c][base+i] == tg) return i;
    return -1;
  endfunction

  task automatic touch(int c, int s, int w, logic [31:0] t);
    int k;
    k = (s << way_bits(c)) + w;
    if (uses[c][k] != 32'hFFFF_FFFF) uses[c][k] = uses[c][k] + 1;
    stamp[c][k] = t;
  endtask

  task automatic pick_victim(int c, int s, output int v);
    int n;
    int base;
    n = 1 << way_bits(c);
    base = s << way_bits(c);
    v = 0;
    if (repl == tlcc_pkg::POL_FIFO) begin
      v = fifo_ptr[c][s] & (n - 1);
      fifo_ptr[c][s] = (v + 1) & (n - 1);
    end else begin
      for (int i = 1; i < n; i++) begin
        if (repl == tlcc_pkg::POL_LFU) begin
          if (uses[c][base+i] < uses[c][base+v] ||
              (uses[c][base+i] == uses[c][base+v] &&
               tag_mem[c][base+i] < tag_mem[c][base+v]))
            v = i;
        end else if (stamp[c][base+i] < stamp[c][base+v]) begin
          v = i;
        end
      end
    end
  endtask

  task automatic place(int c, int s, logic [47:0] tg, bit d, logic [31:0] t,
                       logic [47:0] a, output bit ev, output bit vdirty,
                       output logic [31:0] vt, output logic [47:0] vline);
    int n;
    int w;
    int k;
    n = 1 << way_bits(c);
    ev = 0;
    vdirty = 0;
    vt = '0;
    vline = '0;
    if (fill_lvl[c][s] < n) begin
      w = fill_lvl[c][s];
      fill_lvl[c][s]++;
    end else begin
      pick_victim(c, s, w);
    end
    k = (s << way_bits(c)) + w;
    if (fill_lvl[c][s] >= n && vld[c][k] && w != fill_lvl[c][s] - 1 + n) begin
      ev = 1;
      vdirty = drt[c][k];
      vt = stamp[c][k];
      if (c == DCACHE) vline = line_mem[k];
    end
    vld[c][k] = 1;
    drt[c][k] = d;
    uses[c][k] = 32'd1;
    stamp[c][k] = t;
    tag_mem[c][k] = tg;
    if (c == DCACHE) line_mem[k] = a;
  endtask

  task automatic l2_install(logic [47:0] a, bit d, logic [31:0] t);
    bit ev, vd;
    logic [31:0] vt;
    logic [47:0] vl;
    place(UCACHE, set_of(UCACHE, a, l2bb), tag_of(UCACHE, a, l2bb), d, t, a,
          ev, vd, vt, vl);
    if (ev) begin
      r_l2ev++;
      if (wpol == 1'b0 && vd) begin
        r_wb++;
        r_xfer++;
      end
    end
  endtask

  task automatic l1_install(int c, logic [3:0] bb, logic [47:0] a, bit d,
                            logic [31:0] t);
    bit ev, vd;
    logic [31:0] vt;
    logic [47:0] vl;
    place(c, set_of(c, a, bb), tag_of(c, a, bb), d, t, a, ev, vd, vt, vl);
    if (ev) begin
      r_l1ev = 1;
      // A dirty data line goes straight into L2 without a lookup.
      if (c == DCACHE && wpol == 1'b0 && vd) l2_install(vl, 1'b1, vt);
    end
  endtask

  task automatic l2_lookup(logic [47:0] a, logic [31:0] t, bit clean_on_hit);
    int s2;
    int w2;
    s2 = set_of(UCACHE, a, l2bb);
    w2 = find_way(UCACHE, s2, tag_of(UCACHE, a, l2bb));
    r_l2acc = 1;
    if (w2 < 0) begin
      r_xfer++;
      l2_install(a, 1'b0, t);
    end else begin
      r_l2hit = 1;
      touch(UCACHE, s2, w2, t);
      // A store hit in L2 leaves the line clean.
      if (clean_on_hit) drt[UCACHE][(s2 << 3) + w2] = 0;
    end
  endtask

  task automatic predict_access(logic [47:0] a, logic [1:0] op, logic [31:0] t,
                                output access_outcome_t o);
    int c;
    logic [3:0] bb;
    int s;
    int w;
    r_l1hit = 0; r_l2acc = 0; r_l2hit = 0; r_l1ev = 0;
    r_l2ev = 0; r_wb = 0; r_xfer = 0;
    c = (op == tlcc_pkg::OP_FETCH) ? ICACHE : DCACHE;
    bb = (op == tlcc_pkg::OP_FETCH) ? ibb : dbb;
    if (op != tlcc_pkg::OP_NONE) begin
      s = set_of(c, a, bb);
      w = find_way(c, s, tag_of(c, a, bb));
      if (w >= 0) begin
        r_l1hit = 1;
        touch(c, s, w, t);
        if (op == tlcc_pkg::OP_STORE) drt[c][(s << 2) + w] = 1;
      end else if (op != tlcc_pkg::OP_STORE) begin
        l2_lookup(a, t, 1'b0);
        l1_install(c, bb, a, 1'b0, t);
      end else if (wpol == 1'b0) begin
        l2_lookup(a, t, 1'b1);
        l1_install(c, bb, a, 1'b1, t);
      end else begin
        r_l2acc = 1;
      end
      if (op == tlcc_pkg::OP_STORE && wpol == 1'b1) r_xfer++;
    end
    o.l1_hit = r_l1hit;
    o.l2_accessed = r_l2acc;
    o.l2_hit = r_l2hit;
    o.l1_evicted = r_l1ev;
    o.l2_evictions = r_l2ev[1:0];
    o.l2_writebacks = r_wb[1:0];
    o.transfers = r_xfer[1:0];
  endtask

  task automatic clear_state();
    repl = tlcc_pkg::POL_LRU;
    wpol = 1'b0;
    ibb = 4'd6;
    dbb = 4'd6;
    l2bb = 4'd6;
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 2048; k++) begin
        tag_mem[c][k] = '0;
        vld[c][k] = 0;
        drt[c][k] = 0;
        stamp[c][k] = '0;
        uses[c][k] = '0;
      end
      for (int s = 0; s < 256; s++) begin
        fill_lvl[c][s] = 0;
        fifo_ptr[c][s] = 0;
      end
    end
    outcome_q.delete();
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    clear_state();
  end

  always @(posedge clk) begin
    access_outcome_t exp_o;
    access_outcome_t got_o;
    if (!rst_n) begin
      clear_state();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tlcc_pkg::REG_REPL:  repl = cfg_data[1:0];
          tlcc_pkg::REG_WRITE: wpol = cfg_data[0];
          tlcc_pkg::REG_IBB:   ibb = cfg_data;
          tlcc_pkg::REG_DBB:   dbb = cfg_data;
          tlcc_pkg::REG_L2BB:  l2bb = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_access(in_address, in_opcode, in_access_time, exp_o);
        outcome_q.push_back(exp_o);
      end
      if (out_valid && out_ready) begin
        got_o = {out_l1_hit, out_l2_accessed, out_l2_hit, out_l1_evicted,
                 out_l2_evictions, out_l2_writebacks, out_memory_block_transfers};
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR %0t: result beat with no access outstanding", $realtime);
        end else begin
          exp_o = outcome_q.pop_front();
          if (got_o !== exp_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR %0t: expected %b %b %b %b %0d %0d %0d, actual %b %b %b %b %0d %0d %0d",
                       $realtime,
                       exp_o.l1_hit, exp_o.l2_accessed, exp_o.l2_hit, exp_o.l1_evicted,
                       exp_o.l2_evictions, exp_o.l2_writebacks, exp_o.transfers,
                       got_o.l1_hit, got_o.l2_accessed, got_o.l2_hit, got_o.l1_evicted,
                       got_o.l2_evictions, got_o.l2_writebacks, got_o.transfers);
          end
        end
      end
    end
    pending = outcome_q.size();
  end

endmodule

[dv/two_level_cache_controller_top_tb.sv]
`timescale 1ns / 1ps

module two_level_cache_controller_top_tb;

  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [47:0] in_address = '0;
  logic [1:0]  in_opcode = '0;
  logic [31:0] in_access_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_l1_hit, out_l2_accessed, out_l2_hit, out_l1_evicted;
  logic [1:0]  out_l2_evictions, out_l2_writebacks, out_memory_block_transfers;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;
  int          pending;
  int          mismatches;

  int          hold_requests = 0;
  bit          no_gaps = 0;
  logic [31:0] clock_stamp = 32'd1000;
  logic [47:0] hot_lines [16];

  always #2 clk = ~clk;

  two_level_cache_controller_top DUT (.*);

  tlcc_access_checker u_checker (.*);

  task automatic send_access(logic [47:0] a, logic [1:0] op, logic [31:0] t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_address <= a;
    in_opcode <= op;
    in_access_time <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // The count of outstanding results is sampled away from the active edge.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_access();
    logic [47:0] a;
    logic [1:0] op;
    logic [31:0] t;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      a = hot_lines[$urandom_range(0, 15)];
      if ($urandom_range(0, 3) == 0) a = a | 48'($urandom_range(0, 63));
    end else if (pick < 85) begin
      a = {16'($urandom), 32'($urandom)};
    end else begin
      a = hot_lines[$urandom_range(0, 15)] | {8'hFF, 40'h0};
    end
    pick = $urandom_range(0, 99);
    op = (pick < 40) ? tlcc_pkg::OP_LOAD : (pick < 70) ? tlcc_pkg::OP_STORE :
         (pick < 95) ? tlcc_pkg::OP_FETCH : tlcc_pkg::OP_NONE;
    clock_stamp = clock_stamp + $urandom_range(1, 3);
    t = ($urandom_range(0, 9) == 0) ? 32'($urandom) : clock_stamp;
    send_access(a, op, t);
  endtask

  // Result side: a random hold-off per beat, plus one long hold when asked.
  initial begin
    int holds_done;
    int wait_n;
    holds_done = 0;
    @(posedge clk);
    forever begin
      if (hold_requests > holds_done) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      wait_n = no_gaps ? 0 : $urandom_range(0, 5);
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
          || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0] pols [8] = '{tlcc_pkg::POL_LRU, tlcc_pkg::POL_LFU, tlcc_pkg::POL_FIFO,
                             tlcc_pkg::POL_RSVD, tlcc_pkg::POL_LRU, tlcc_pkg::POL_LFU,
                             tlcc_pkg::POL_FIFO, tlcc_pkg::POL_LRU};
    logic [3:0] bbs [8][3] = '{'{6, 6, 6}, '{0, 0, 0}, '{12, 12, 12}, '{3, 9, 5},
                               '{0, 12, 6}, '{12, 0, 4}, '{6, 6, 0}, '{1, 7, 12}};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every opcode, hit/miss/eviction paths at reset config.
    send_access(48'h0, tlcc_pkg::OP_LOAD, 32'h0);
    send_access(48'h0, tlcc_pkg::OP_LOAD, 32'hFFFF_FFFF);
    send_access(48'hFFFF_FFFF_FFFF, tlcc_pkg::OP_STORE, 32'h1);
    send_access(48'hFFFF_FFFF_FFFF, tlcc_pkg::OP_FETCH, 32'h2);
    send_access(48'hFFFF_FFFF_FFFF, tlcc_pkg::OP_NONE, 32'hFFFF_FFFF);
    send_access(48'h0, tlcc_pkg::OP_STORE, 32'h3);
    // Five stores to one set fill the ways and force a dirty victim into L2.
    for (int i = 0; i < 5; i++) send_access(48'(i) << 12, tlcc_pkg::OP_STORE, 32'(10 + i));
    for (int i = 0; i < 5; i++) send_access(48'(i) << 12, tlcc_pkg::OP_FETCH, 32'(20 + i));
    send_access(48'h1000, tlcc_pkg::OP_STORE, 32'h30);
    for (int i = 5; i < 11; i++) send_access(48'(i) << 14, tlcc_pkg::OP_LOAD, 32'(40 + i));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(tlcc_pkg::REG_REPL, {2'b00, pols[ph]});
      write_reg(tlcc_pkg::REG_WRITE, {3'b000, ph[0]});
      write_reg(tlcc_pkg::REG_IBB, bbs[ph][0]);
      write_reg(tlcc_pkg::REG_DBB, bbs[ph][1]);
      write_reg(tlcc_pkg::REG_L2BB, bbs[ph][2]);
      for (int i = 0; i < 16; i++)
        hot_lines[i] = (48'($urandom_range(0, 11)) << 22) |
                       (48'($urandom_range(0, 1)) << 15) |
                       (48'($urandom_range(0, 1)) << 7);
      no_gaps = (ph == 3);
      for (int i = 0; i < 48; i++) begin
        if (ph == 2 && i == 10) hold_requests++;
        random_access();
      end
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
